FILE: sv/dls_pkg.sv
// shared constants and types of the diagonal laplacian stencil
`timescale 1ns / 1ps

package dls_pkg;

    // frame geometry limits
    localparam int MAX_COLS   = 512;
    localparam int MAX_ROWS   = 256;
    localparam int COL_W      = 9;     // column counter, out_col
    localparam int ROW_W      = 8;     // row counter, out_row
    localparam int COLS_CFG_W = 10;    // image_cols register
    localparam int ROWS_CFG_W = 9;     // image_rows register

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COLS_CFG_W;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'b1;

    localparam logic [COLS_CFG_W-1:0] COLS_RST = 10'd401;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RST = 9'd200;

    // position of one accepted pixel and what it triggers
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             emit;   // completes the window of an interior pixel
        logic             last;   // last pixel of the frame
    } t_scan;

endpackage

FILE: sv/dls_line_mem.sv
// two line stores packed side by side in one synchronous memory
`timescale 1ns / 1ps

module dls_line_mem #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [dls_pkg::COL_W-1:0]   i_rd_addr,
    output logic [2*SAMPLE_WIDTH-1:0]   o_rd_data,
    input  logic                        i_wr_en,
    input  logic [dls_pkg::COL_W-1:0]   i_wr_addr,
    input  logic [2*SAMPLE_WIDTH-1:0]   i_wr_data
);

    // low half: previous row, high half: row before it
    logic [2*SAMPLE_WIDTH-1:0] mem [dls_pkg::MAX_COLS];
    logic [2*SAMPLE_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/dls_scan.sv
// configuration registers and raster position counters
`timescale 1ns / 1ps

module dls_scan (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dls_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dls_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_adv,
    output dls_pkg::t_scan                   o_scan
);

    logic [dls_pkg::COLS_CFG_W-1:0] r_cols;
    logic [dls_pkg::ROWS_CFG_W-1:0] r_rows;
    logic [dls_pkg::COL_W-1:0]      r_col, n_col;
    logic [dls_pkg::ROW_W-1:0]      r_row, n_row;
    logic [dls_pkg::COLS_CFG_W-1:0] cols_eff;
    logic [dls_pkg::ROWS_CFG_W-1:0] rows_eff;
    logic                           last_col;
    logic                           last_row;

    // out-of-range settings saturate to 3..max
    always_comb begin
        if (r_cols < dls_pkg::COLS_CFG_W'(3)) begin
            cols_eff = dls_pkg::COLS_CFG_W'(3);
        end else if (r_cols > dls_pkg::COLS_CFG_W'(dls_pkg::MAX_COLS)) begin
            cols_eff = dls_pkg::COLS_CFG_W'(dls_pkg::MAX_COLS);
        end else begin
            cols_eff = r_cols;
        end
        if (r_rows < dls_pkg::ROWS_CFG_W'(3)) begin
            rows_eff = dls_pkg::ROWS_CFG_W'(3);
        end else if (r_rows > dls_pkg::ROWS_CFG_W'(dls_pkg::MAX_ROWS)) begin
            rows_eff = dls_pkg::ROWS_CFG_W'(dls_pkg::MAX_ROWS);
        end else begin
            rows_eff = r_rows;
        end
    end

    assign last_col = ({1'b0, r_col} + dls_pkg::COLS_CFG_W'(1)) >= cols_eff;
    assign last_row = ({1'b0, r_row} + dls_pkg::ROWS_CFG_W'(1)) >= rows_eff;

    always_comb begin
        n_col = r_col + dls_pkg::COL_W'(1);
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : (r_row + dls_pkg::ROW_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= dls_pkg::COLS_RST;
            r_rows <= dls_pkg::ROWS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dls_pkg::CFG_IMAGE_COLS: r_cols <= i_cfg_data;
                dls_pkg::CFG_IMAGE_ROWS: r_rows <= i_cfg_data[dls_pkg::ROWS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_scan.col  = r_col;
    assign o_scan.row  = r_row;
    assign o_scan.emit = (r_row >= dls_pkg::ROW_W'(2)) && (r_col >= dls_pkg::COL_W'(2));
    assign o_scan.last = last_col && last_row;

endmodule

FILE: sv/diagonal_laplacian_stencil.sv
// top level: diagonal laplacian 3x3 stencil over a raster pixel stream
//
//  channel   dir  handshake                     payload
//  -------   ---  ----------------------------  -----------------------------------
//  s_axis    in   i_s_axis_tvalid/o_..._tready  tdata: sample
//  m_axis    out  o_m_axis_tvalid/i_..._tready  tdata: filtered, out_row, out_col;
//                                               tlast: frame_last
//  cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
//  one pixel per cycle unless the input stalls as described below; a result leaves
//    after the pixel that completes its window (line memory read into the second
//    stage, then stencil add into the output register)
//  the line memory is read when a pixel is accepted and written back when that
//    pixel leaves the second stage, so each memory port sees one access a cycle
//  synchronous active-low reset clears counters, valids and the window taps;
//    the line memory is not cleared, every column in use is written on the first row
//  input stalls only while a result is held in the output register and the
//    pixel in the second stage has a result of its own to hand over
`timescale 1ns / 1ps

module diagonal_laplacian_stencil #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [dls_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dls_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // pixel input
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample, zero fill above
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // result output
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // from bit 0: filtered (SAMPLE_WIDTH+3), out_row (8), out_col (9), zero fill
    output logic [((SAMPLE_WIDTH+3+dls_pkg::ROW_W+dls_pkg::COL_W+7)/8)*8-1:0]
                                            o_m_axis_tdata,
    output logic                            o_m_axis_tlast    // frame_last
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int FW      = SAMPLE_WIDTH + 3;
    localparam int OUT_W   = ((FW + dls_pkg::ROW_W + dls_pkg::COL_W + 7) / 8) * 8;
    localparam int PAD_W   = OUT_W - FW - dls_pkg::ROW_W - dls_pkg::COL_W;

    // input side
    logic                 s_xfer;
    dls_pkg::t_scan       scan;

    // second stage: pixel waiting for its line memory data
    logic                 r_v1;
    logic [SW-1:0]        r_s1;
    dls_pkg::t_scan       r_scan1;
    logic                 adv1;
    logic [2*SW-1:0]      rd_data;
    logic [SW-1:0]        p1;
    logic [SW-1:0]        p2;

    // window taps: current row delayed 1 and 2, previous row delayed 1,
    // row before delayed 1 and 2
    logic [SW-1:0]        r_tap0, r_tap1, r_tap2, r_tap3, r_tap4;

    logic signed [FW-1:0] n_filt;

    // output register
    logic                        r_ov;
    logic signed [FW-1:0]        r_filt;
    logic [dls_pkg::ROW_W-1:0]   r_orow;
    logic [dls_pkg::COL_W-1:0]   r_ocol;
    logic                        r_olast;

    // stage two moves on unless its result would land on a held result
    assign adv1            = r_v1 && (!r_scan1.emit || !r_ov || i_m_axis_tready);
    assign o_s_axis_tready = !r_v1 || adv1;
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;

    dls_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_adv      (s_xfer),
        .o_scan     (scan)
    );

    // consecutive pixels hit different columns (at least three per row),
    // so the write-back never collides with the read of the next pixel
    dls_line_mem #(
        .SAMPLE_WIDTH (SW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (s_xfer),
        .i_rd_addr (scan.col),
        .o_rd_data (rd_data),
        .i_wr_en   (adv1),
        .i_wr_addr (r_scan1.col),
        .i_wr_data ({p1, r_s1})
    );

    assign p1 = rd_data[SW-1:0];
    assign p2 = rd_data[2*SW-1:SW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_xfer) begin
            r_v1 <= 1'b1;
        end else if (adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_s1    <= i_s_axis_tdata[SW-1:0];
            r_scan1 <= scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap0 <= '0;
            r_tap1 <= '0;
            r_tap2 <= '0;
            r_tap3 <= '0;
            r_tap4 <= '0;
        end else if (adv1) begin
            r_tap4 <= r_tap3;
            r_tap3 <= p2;
            r_tap2 <= p1;
            r_tap1 <= r_tap0;
            r_tap0 <= r_s1;
        end
    end

    // corners (r-2,c-2) (r-2,c) (r,c-2) (r,c) minus four times centre (r-1,c-1)
    always_comb begin
        n_filt = FW'(signed'(r_tap4)) + FW'(signed'(p2)) + FW'(signed'(r_tap1))
               + FW'(signed'(r_s1)) - (FW'(signed'(r_tap2)) <<< 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv1 && r_scan1.emit) begin
            r_ov <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && r_scan1.emit) begin
            r_filt  <= n_filt;
            r_orow  <= r_scan1.row - dls_pkg::ROW_W'(1);
            r_ocol  <= r_scan1.col - dls_pkg::COL_W'(1);
            r_olast <= r_scan1.last;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_ocol, r_orow, r_filt};
    assign o_m_axis_tlast  = r_olast;

endmodule

FILE: sv/dls_checker.sv
// port-level checks of the stencil, bound to the top level
`timescale 1ns / 1ps

module dls_checker #(
    parameter int SAMPLE_WIDTH = 32
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [((SAMPLE_WIDTH+3+dls_pkg::ROW_W+dls_pkg::COL_W+7)/8)*8-1:0]
                                           o_m_axis_tdata,
    input logic                            o_m_axis_tlast
);

    localparam int ROW_LO = SAMPLE_WIDTH + 3;
    localparam int COL_LO = ROW_LO + dls_pkg::ROW_W;

    logic [dls_pkg::ROW_W-1:0] out_row;
    logic [dls_pkg::COL_W-1:0] out_col;

    assign out_row = o_m_axis_tdata[COL_LO-1:ROW_LO];
    assign out_col = o_m_axis_tdata[COL_LO+dls_pkg::COL_W-1:COL_LO];

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // input backpressure only comes from a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output backpressure");

    // results never name row or column zero or the all-ones row or column
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> out_row != '0 && out_col != '0
            && out_row != '1 && out_col != '1)
        else $error("result on a border position");

endmodule

bind diagonal_laplacian_stencil dls_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dls_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
